@@ hw/rtl/ifs_pkg.sv @@
package ifs_pkg;

    localparam int POS_W     = 5;
    localparam int NUM_FLAGS = 14;
    localparam int CODE_W    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // candidate flag bits
    localparam int F_PNG  = 0;
    localparam int F_JPEG = 1;
    localparam int F_GIF7 = 2;
    localparam int F_GIF9 = 3;
    localparam int F_RIFF = 4;
    localparam int F_WEBP = 5;
    localparam int F_BMP  = 6;
    localparam int F_TGAT = 7;
    localparam int F_TGAD = 8;
    localparam int F_PSD  = 9;
    localparam int F_RAD  = 10;
    localparam int F_RGBE = 11;
    localparam int F_P5   = 12;
    localparam int F_P6   = 13;

    // format codes
    localparam logic [CODE_W-1:0] FMT_UNKNOWN = 4'd0;
    localparam logic [CODE_W-1:0] FMT_PNG     = 4'd1;
    localparam logic [CODE_W-1:0] FMT_JPEG    = 4'd2;
    localparam logic [CODE_W-1:0] FMT_GIF     = 4'd3;
    localparam logic [CODE_W-1:0] FMT_WEBP    = 4'd4;
    localparam logic [CODE_W-1:0] FMT_BMP     = 4'd5;
    localparam logic [CODE_W-1:0] FMT_TGA     = 4'd6;
    localparam logic [CODE_W-1:0] FMT_PSD     = 4'd7;
    localparam logic [CODE_W-1:0] FMT_HDR     = 4'd8;
    localparam logic [CODE_W-1:0] FMT_PNM     = 4'd9;

    // last-byte positions (length minus one) for the length rules
    localparam logic [POS_W-1:0] POS_MIN_ANY  = 5'd7;
    localparam logic [POS_W-1:0] POS_MIN_WEBP = 5'd11;
    localparam logic [POS_W-1:0] POS_MIN_TGA  = 5'd17;
    localparam logic [POS_W-1:0] POS_MIN_RAD  = 5'd9;
    localparam logic [POS_W-1:0] POS_TGA_TYPE = 5'd2;
    localparam logic [POS_W-1:0] POS_TGA_BPP  = 5'd16;
    localparam logic [POS_W-1:0] POS_WEBP_LO  = 5'd8;

    // signatures, padded to a power of two; padding is never compared
    localparam logic [7:0] SIG_PNG  [8]  = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                             8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] SIG_JPEG [4]  = '{8'hFF, 8'hD8, 8'hFF, 8'h00};
    localparam logic [7:0] SIG_GIF7 [8]  = '{"G", "I", "F", "8", "7", "a", 8'h00, 8'h00};
    localparam logic [7:0] SIG_GIF9 [8]  = '{"G", "I", "F", "8", "9", "a", 8'h00, 8'h00};
    localparam logic [7:0] SIG_RIFF [4]  = '{"R", "I", "F", "F"};
    localparam logic [7:0] SIG_WEBP [4]  = '{"W", "E", "B", "P"};
    localparam logic [7:0] SIG_BMP  [2]  = '{"B", "M"};
    localparam logic [7:0] SIG_PSD  [4]  = '{"8", "B", "P", "S"};
    localparam logic [7:0] SIG_RAD  [16] = '{"#", "?", "R", "A", "D", "I", "A", "N",
                                             "C", "E", 8'h00, 8'h00, 8'h00, 8'h00,
                                             8'h00, 8'h00};
    localparam logic [7:0] SIG_RGBE [8]  = '{"#", "?", "R", "G", "B", "E", 8'h00, 8'h00};
    localparam logic [7:0] SIG_P5   [2]  = '{"P", "5"};
    localparam logic [7:0] SIG_P6   [2]  = '{"P", "6"};

    typedef struct packed {
        logic [NUM_FLAGS-1:0] flags;
        logic [POS_W-1:0]     pos;
    } t_decision;

endpackage

@@ hw/rtl/ifs_front.sv @@
module ifs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_push,
    output ifs_pkg::t_decision o_decision
);
    import ifs_pkg::*;

    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     n_pos;
    logic [NUM_FLAGS-1:0] r_flags;
    logic [NUM_FLAGS-1:0] n_flags;
    logic [NUM_FLAGS-1:0] upd_flags;
    logic [7:0]           b;

    assign b = i_data_byte;

    always_comb begin
        upd_flags = r_flags;
        if (r_pos < 5'd8 && SIG_PNG[r_pos[2:0]] != b) upd_flags[F_PNG] = 1'b0;
        if (r_pos < 5'd3 && SIG_JPEG[r_pos[1:0]] != b) upd_flags[F_JPEG] = 1'b0;
        if (r_pos < 5'd6 && SIG_GIF7[r_pos[2:0]] != b) upd_flags[F_GIF7] = 1'b0;
        if (r_pos < 5'd6 && SIG_GIF9[r_pos[2:0]] != b) upd_flags[F_GIF9] = 1'b0;
        if (r_pos < 5'd4 && SIG_RIFF[r_pos[1:0]] != b) upd_flags[F_RIFF] = 1'b0;
        // WEBP sits at offsets 8..11, so the low two bits index it directly
        if (r_pos >= POS_WEBP_LO && r_pos < 5'd12 && SIG_WEBP[r_pos[1:0]] != b)
            upd_flags[F_WEBP] = 1'b0;
        if (r_pos < 5'd2 && SIG_BMP[r_pos[0]] != b) upd_flags[F_BMP] = 1'b0;
        if (r_pos < 5'd4 && SIG_PSD[r_pos[1:0]] != b) upd_flags[F_PSD] = 1'b0;
        if (r_pos < 5'd10 && SIG_RAD[r_pos[3:0]] != b) upd_flags[F_RAD] = 1'b0;
        if (r_pos < 5'd6 && SIG_RGBE[r_pos[2:0]] != b) upd_flags[F_RGBE] = 1'b0;
        if (r_pos < 5'd2 && SIG_P5[r_pos[0]] != b) upd_flags[F_P5] = 1'b0;
        if (r_pos < 5'd2 && SIG_P6[r_pos[0]] != b) upd_flags[F_P6] = 1'b0;
        if (r_pos == POS_TGA_TYPE &&
            !(b == 8'd2 || b == 8'd3 || b == 8'd10 || b == 8'd11))
            upd_flags[F_TGAT] = 1'b0;
        if (r_pos == POS_TGA_BPP &&
            !(b == 8'd8 || b == 8'd16 || b == 8'd24 || b == 8'd32))
            upd_flags[F_TGAD] = 1'b0;
    end

    always_comb begin
        n_pos   = r_pos;
        n_flags = r_flags;
        if (i_accept) begin
            if (i_last_byte) begin
                // start a new buffer
                n_pos   = '0;
                n_flags = '1;
            end else begin
                n_flags = upd_flags;
                if (r_pos != POS_MAX) n_pos = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= '1;
        end else begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
        end
    end

    assign o_push           = i_accept && i_last_byte;
    assign o_decision.flags = upd_flags;
    assign o_decision.pos   = r_pos;

`ifndef NO_ASSERTIONS
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == '0 && r_flags == '1))
        else $error("front did not restart after last byte");
`endif

endmodule

@@ hw/rtl/ifs_queue.sv @@
module ifs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ifs_pkg::t_decision i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ifs_pkg::t_decision o_data
);
    import ifs_pkg::*;

    t_decision         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("queue count lost a pop");
`endif

endmodule

@@ hw/rtl/ifs_back.sv @@
module ifs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  ifs_pkg::t_decision        i_decision,
    output logic                      o_pop,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [ifs_pkg::CODE_W-1:0] o_format_code
);
    import ifs_pkg::*;

    logic              r_valid;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] code;
    logic [NUM_FLAGS-1:0] f;
    logic [POS_W-1:0]  p;

    assign f = i_decision.flags;
    assign p = i_decision.pos;

    // pick the first live candidate in priority order
    always_comb begin
        code = FMT_UNKNOWN;
        if (p >= POS_MIN_ANY) begin
            if (f[F_PNG])                                     code = FMT_PNG;
            else if (f[F_JPEG])                               code = FMT_JPEG;
            else if (f[F_GIF7] || f[F_GIF9])                  code = FMT_GIF;
            else if (p >= POS_MIN_WEBP && f[F_RIFF] && f[F_WEBP]) code = FMT_WEBP;
            else if (f[F_BMP])                                code = FMT_BMP;
            else if (p >= POS_MIN_TGA && f[F_TGAT] && f[F_TGAD])  code = FMT_TGA;
            else if (f[F_PSD])                                code = FMT_PSD;
            else if (p >= POS_MIN_RAD && f[F_RAD])            code = FMT_HDR;
            else if (f[F_RGBE])                               code = FMT_HDR;
            else if (f[F_P5] || f[F_P6])                      code = FMT_PNM;
        end
    end

    // load the output register whenever it is free or being drained
    assign o_pop = !i_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_code <= code;
    end

    assign o_valid       = r_valid;
    assign o_format_code = r_code;

`ifndef NO_ASSERTIONS
    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped result not presented");
`endif

endmodule

@@ hw/rtl/image_format_sniffer.sv @@
// Image format sniffer: identifies a file format from its leading bytes.
// Input channel: one header byte per beat on i_data_byte, with i_last_byte
// marking the final byte of the buffer; a beat is taken when i_valid is high
// and o_stall is low. Output channel: one o_format_code beat per buffer
// (0 unknown, 1 png, 2 jpeg, 3 gif, 4 webp, 5 bmp, 6 tga, 7 psd, 8 hdr,
// 9 pnm), taken when o_valid is high and i_stall is low.
// Throughput: one byte per cycle while o_stall is low, sustained also
// across back-to-back buffers; all signature compares run in parallel
// in the front stage. The last byte's decision is written to the queue,
// then loaded into the free or draining output register, raising o_valid.
// A two-entry queue sits between the byte front end and the output register.
// When the receiver stalls, the output register holds its code and the queue
// fills; o_stall rises only once the queue is full.
// Reset (synchronous, active low) clears the byte position, sets all match
// flags, empties the queue and drops o_valid. No clearing pass is needed.
module image_format_sniffer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ifs_pkg::CODE_W-1:0] o_format_code
);
    import ifs_pkg::*;

    logic      accept;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    t_decision front_dec;
    t_decision head_dec;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    ifs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_decision  (front_dec)
    );

    ifs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_dec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (head_dec)
    );

    ifs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_decision    (head_dec),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_format_code (o_format_code)
    );

endmodule

@@ dv/tb_image_format_sniffer.sv @@
module tb_image_format_sniffer;
    import ifs_pkg::*;

    localparam int          MAX_HDR     = 40;
    localparam int          LONG_HOLD   = 300;
    localparam int          DRAIN_WAIT  = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Magic strings per candidate flag, indexed like the flag bits.
    localparam logic [7:0] MAGIC [NUM_FLAGS][10] = '{
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 8'h00, 8'h00},
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"G", "I", "F", "8", "7", "a", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"G", "I", "F", "8", "9", "a", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"R", "I", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "E", "B", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"B", "M", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{default: 8'h00},
        '{default: 8'h00},
        '{"8", "B", "P", "S", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"#", "?", "R", "A", "D", "I", "A", "N", "C", "E"},
        '{"#", "?", "R", "G", "B", "E", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "5", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "6", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int MAGIC_LEN [NUM_FLAGS] = '{8, 3, 6, 6, 4, 4, 2, 0, 0, 4, 10, 6, 2, 2};
    localparam int MAGIC_OFF [NUM_FLAGS] = '{0, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam logic [7:0] TGA_TYPES  [4] = '{8'd2, 8'd3, 8'd10, 8'd11};
    localparam logic [7:0] TGA_DEPTHS [4] = '{8'd8, 8'd16, 8'd24, 8'd32};

    class format_scoreboard;
        logic [POS_W-1:0]     pos;
        logic [NUM_FLAGS-1:0] alive;
        logic [CODE_W-1:0]    expected_codes [$];
        int unsigned          mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            pos   = '0;
            alive = '1;
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        // Update the candidate flags with one accepted byte; on the last byte
        // decide the format and queue the code.
        function void note_byte(logic [7:0] b, logic last);
            int               at;
            int               len;
            logic [CODE_W-1:0] code;
            at = int'(pos);
            for (int c = 0; c < NUM_FLAGS; c++) begin
                if (at >= MAGIC_OFF[c] && at - MAGIC_OFF[c] < MAGIC_LEN[c] &&
                    MAGIC[c][at - MAGIC_OFF[c]] != b)
                    alive[c] = 1'b0;
            end
            if (at == 2 && !(b inside {8'd2, 8'd3, 8'd10, 8'd11}))
                alive[F_TGAT] = 1'b0;
            if (at == 16 && !(b inside {8'd8, 8'd16, 8'd24, 8'd32}))
                alive[F_TGAD] = 1'b0;
            if (pos != POS_MAX)
                pos = pos + 1'b1;
            if (!last)
                return;

            len  = at + 1;
            code = FMT_UNKNOWN;
            if (len >= 8) begin
                if (alive[F_PNG])
                    code = FMT_PNG;
                else if (alive[F_JPEG])
                    code = FMT_JPEG;
                else if (alive[F_GIF7] || alive[F_GIF9])
                    code = FMT_GIF;
                else if (len >= 12 && alive[F_RIFF] && alive[F_WEBP])
                    code = FMT_WEBP;
                else if (alive[F_BMP])
                    code = FMT_BMP;
                else if (len >= 18 && alive[F_TGAT] && alive[F_TGAD])
                    code = FMT_TGA;
                else if (alive[F_PSD])
                    code = FMT_PSD;
                else if (len >= 10 && alive[F_RAD])
                    code = FMT_HDR;
                else if (alive[F_RGBE])
                    code = FMT_HDR;
                else if (alive[F_P5] || alive[F_P6])
                    code = FMT_PNM;
            end
            expected_codes.push_back(code);
            restart();
        endfunction

        function void check_code(logic [CODE_W-1:0] actual);
            logic [CODE_W-1:0] want;
            if (expected_codes.size() == 0) begin
                $error("format_code: expected none, actual %0d", actual);
                mismatches++;
                return;
            end
            want = expected_codes.pop_front();
            if (want !== actual) begin
                $error("format_code: expected %0d, actual %0d", want, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic [7:0]        i_data_byte = 8'h00;
    logic              i_last_byte = 1'b0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [CODE_W-1:0] o_format_code;

    format_scoreboard sb = new();

    int unsigned sender_idle_pct = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned bytes_sent      = 0;
    bit          hold_request    = 1'b0;

    image_format_sniffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_format_code (o_format_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_byte(i_data_byte, i_last_byte);
            if (o_valid && !i_stall)
                sb.check_code(o_format_code);
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one beat and hold it until taken; return on the accepting edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Build a header around one candidate's signature (cand == NUM_FLAGS for
    // pure noise), optionally spoil one early byte, then send len bytes.
    task automatic send_header(input int cand, input int len, input bit spoil);
        logic [7:0] hdr [MAX_HDR];
        for (int i = 0; i < MAX_HDR; i++)
            hdr[i] = 8'($urandom);
        if (cand == F_RIFF || cand == F_WEBP) begin
            for (int i = 0; i < 4; i++) begin
                hdr[i]     = MAGIC[F_RIFF][i];
                hdr[8 + i] = MAGIC[F_WEBP][i];
            end
        end else if (cand == F_TGAT || cand == F_TGAD) begin
            hdr[2]  = TGA_TYPES[$urandom_range(3)];
            hdr[16] = TGA_DEPTHS[$urandom_range(3)];
        end else if (cand < NUM_FLAGS) begin
            for (int i = 0; i < MAGIC_LEN[cand]; i++)
                hdr[MAGIC_OFF[cand] + i] = MAGIC[cand][i];
        end
        if (spoil)
            hdr[$urandom_range(17)] = 8'($urandom);
        for (int i = 0; i < len; i++)
            send_byte(hdr[i], i == len - 1);
    endtask

    // Lengths cluster on the short, webp, radiance and tga boundaries.
    function automatic int pick_length();
        int sel;
        int edges [9];
        edges = '{7, 8, 9, 10, 11, 12, 17, 18, 19};
        sel   = $urandom_range(9);
        if (sel == 0)
            return $urandom_range(1, 7);
        if (sel <= 5)
            return edges[$urandom_range(8)];
        if (sel <= 8)
            return $urandom_range(8, 24);
        return $urandom_range(30, MAX_HDR);
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned target, input int unsigned tx_pct,
                             input int unsigned rx_pct, input bit long_hold);
        int unsigned start;
        start           = bytes_sent;
        sender_idle_pct = tx_pct;
        recv_idle_pct   = rx_pct;
        if (long_hold) begin
            // Back up the output while one-byte buffers keep coming.
            hold_request = 1'b1;
            repeat (12)
                send_header(NUM_FLAGS, 1, 1'b0);
        end
        while (bytes_sent - start < target)
            send_header($urandom_range(NUM_FLAGS), pick_length(), $urandom_range(4) == 0);
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_header(F_PNG, 8, 1'b0);
        send_header(F_WEBP, 12, 1'b0);
        drain();

        run_phase(480, 9, 65, 1'b1);
        drain();
        run_phase(480, 65, 9, 1'b0);
        drain();
        run_phase(480, 0, 0, 1'b0);
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
